// ===== rtl/core/mnet_pkg.sv =====
// Package for the MIDI note event tracker: field widths, event and action codes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package mnet_pkg;

  localparam int CMD_W      = 2;
  localparam int DELTA_W    = 28;
  localparam int STATUS_W   = 8;
  localparam int KEY_W      = 7;
  localparam int TRACK_W    = 16;
  localparam int KIND_W     = 7;
  localparam int LEN_W      = 28;
  localparam int TEMPO_W    = 24;
  localparam int INDEX_W    = 16;
  localparam int MS_W       = 32;
  localparam int TICKS_W    = 32;
  localparam int TPQ_W      = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam int PROD_W     = TICKS_W + TEMPO_W;
  localparam int DVSR_W     = 25;
  localparam int DIV_STEPS  = MS_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);
  localparam int MS_PER_S   = 1000;
  localparam int TPQ_RESET  = 480;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHAN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SYSEX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_META  = 2'd3;

  localparam logic [3:0] NIB_NOTE_ON  = 4'd9;
  localparam logic [3:0] NIB_NOTE_OFF = 4'd8;

  localparam logic [KIND_W-1:0] META_TEMPO     = 7'h51;
  localparam logic [LEN_W-1:0]  META_TEMPO_LEN = 28'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPQ          = 1'd1;

  typedef logic [1:0] action_t;
  localparam action_t ACT_NONE   = 2'd0;
  localparam action_t ACT_CLOSE  = 2'd1;
  localparam action_t ACT_LEGATO = 2'd2;
  localparam action_t ACT_OPEN   = 2'd3;

  typedef struct packed {
    logic accept;
    logic mul;
    logic check;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_time;
    logic sat;
    logic can_finish;
  } ctrl_stat_t;

endpackage

// ===== rtl/core/mnet_datapath.sv =====
// Datapath of the MIDI note event tracker: event decode, tick and tempo state,
// note state, the tick-to-millisecond multiplier and divider, and the result register.
// Depends on mnet_pkg.
module mnet_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mnet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mnet_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [mnet_pkg::CMD_W-1:0]          in_cmd,
  input  logic [mnet_pkg::DELTA_W-1:0]        in_delta_ticks,
  input  logic [mnet_pkg::STATUS_W-1:0]       in_status_byte,
  input  logic [mnet_pkg::KEY_W-1:0]          in_key_number,
  input  logic [mnet_pkg::KEY_W-1:0]          in_key_velocity,
  input  logic [mnet_pkg::TRACK_W-1:0]        in_track_number,
  input  logic [mnet_pkg::KIND_W-1:0]         in_meta_kind,
  input  logic [mnet_pkg::LEN_W-1:0]          in_meta_length,
  input  logic [mnet_pkg::TEMPO_W-1:0]        in_tempo_value,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [mnet_pkg::INDEX_W-1:0]        out_note_index,
  output logic [mnet_pkg::MS_W-1:0]           out_start_ms,
  output logic [mnet_pkg::MS_W-1:0]           out_end_ms,
  output logic [mnet_pkg::KEY_W-1:0]          out_pitch,
  output logic [mnet_pkg::KEY_W-1:0]          out_velocity,
  input  mnet_pkg::ctrl_cmd_t                 cmd,
  output mnet_pkg::ctrl_stat_t                stat
);

  logic [mnet_pkg::TRACK_W-1:0]  track_select_r;
  logic [mnet_pkg::TPQ_W-1:0]    tpq_r;
  logic [mnet_pkg::TICKS_W-1:0]  elapsed_r, elapsed_nxt;
  logic [mnet_pkg::TEMPO_W-1:0]  tempo_r, tempo_nxt;
  logic                          active_r, active_nxt;
  logic                          open_r;
  logic [mnet_pkg::KEY_W-1:0]    open_pitch_r;
  logic [mnet_pkg::KEY_W-1:0]    open_vel_r;
  logic [mnet_pkg::MS_W-1:0]     open_start_r;
  logic [mnet_pkg::INDEX_W-1:0]  counter_r, counter_inc;
  logic [mnet_pkg::KEY_W-1:0]    key_r, vel_r;
  mnet_pkg::action_t             act_r, act_nxt;
  logic [mnet_pkg::PROD_W-1:0]   prod_r;
  logic [mnet_pkg::DVSR_W-1:0]   dvsr_r;
  logic [mnet_pkg::DVSR_W-1:0]   rem_r;
  logic [mnet_pkg::MS_W-1:0]     quo_r;
  logic                          out_valid_r;
  logic [mnet_pkg::INDEX_W-1:0]  out_index_r;
  logic [mnet_pkg::MS_W-1:0]     out_start_r, out_end_r;
  logic [mnet_pkg::KEY_W-1:0]    out_pitch_r, out_vel_r;

  logic [3:0]                    nib;
  logic [mnet_pkg::TICKS_W:0]    adv_sum;
  logic [mnet_pkg::TICKS_W-1:0]  adv_sat;
  logic [mnet_pkg::TPQ_W-1:0]    tpq_eff;
  logic [mnet_pkg::DVSR_W:0]     rem_sh;
  logic                          rem_ge;
  logic [mnet_pkg::DVSR_W:0]     rem_diff;
  logic                          emits, out_free, load_out;

  assign nib     = in_status_byte[7:4];
  assign adv_sum = {1'b0, elapsed_r} + (mnet_pkg::TICKS_W + 1)'(in_delta_ticks);
  assign adv_sat = adv_sum[mnet_pkg::TICKS_W] ? '1 : adv_sum[mnet_pkg::TICKS_W-1:0];
  assign tpq_eff = (tpq_r == '0) ? mnet_pkg::TPQ_W'(1) : tpq_r;

  always_comb begin
    elapsed_nxt = elapsed_r;
    tempo_nxt   = tempo_r;
    active_nxt  = active_r;
    act_nxt     = mnet_pkg::ACT_NONE;
    case (in_cmd)
      mnet_pkg::CMD_START: begin
        elapsed_nxt = '0;
        active_nxt  = (in_track_number == track_select_r);
      end
      mnet_pkg::CMD_SYSEX: begin
        if (active_r) elapsed_nxt = adv_sat;
      end
      mnet_pkg::CMD_META: begin
        if (active_r) elapsed_nxt = adv_sat;
        if (in_meta_kind == mnet_pkg::META_TEMPO && in_meta_length == mnet_pkg::META_TEMPO_LEN)
          tempo_nxt = in_tempo_value;
      end
      default: begin
        if (active_r) begin
          elapsed_nxt = adv_sat;
          if (nib == mnet_pkg::NIB_NOTE_ON) begin
            if (open_r) begin
              if (open_pitch_r == in_key_number) begin
                if (in_key_velocity == '0) act_nxt = mnet_pkg::ACT_CLOSE;
              end else if (in_key_velocity != '0) begin
                act_nxt = mnet_pkg::ACT_LEGATO;
              end
            end else if (in_key_velocity != '0) begin
              act_nxt = mnet_pkg::ACT_OPEN;
            end
          end else if (nib == mnet_pkg::NIB_NOTE_OFF && open_r) begin
            act_nxt = mnet_pkg::ACT_CLOSE;
          end
        end
      end
    endcase
  end

  assign rem_sh   = {rem_r, quo_r[mnet_pkg::MS_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvsr_r};
  assign rem_diff = rem_sh - {1'b0, dvsr_r};

  assign emits    = (act_r == mnet_pkg::ACT_CLOSE) || (act_r == mnet_pkg::ACT_LEGATO);
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = cmd.finish && emits;

  assign counter_inc = (counter_r == '1) ? mnet_pkg::INDEX_W'(1) : counter_r + 1'b1;

  assign stat.needs_time = (act_nxt != mnet_pkg::ACT_NONE);
  assign stat.sat        = {1'b0, prod_r[mnet_pkg::PROD_W-1:mnet_pkg::MS_W]} >= dvsr_r;
  assign stat.can_finish = !emits || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_select_r <= '0;
      tpq_r          <= mnet_pkg::TPQ_W'(mnet_pkg::TPQ_RESET);
      elapsed_r      <= '0;
      tempo_r        <= '0;
      active_r       <= 1'b0;
      open_r         <= 1'b0;
      open_pitch_r   <= '0;
      open_vel_r     <= '0;
      open_start_r   <= '0;
      counter_r      <= '0;
      act_r          <= mnet_pkg::ACT_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mnet_pkg::REG_TRACK_SELECT: track_select_r <= cfg_wdata;
          mnet_pkg::REG_TPQ:          tpq_r <= cfg_wdata[mnet_pkg::TPQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        elapsed_r <= elapsed_nxt;
        tempo_r   <= tempo_nxt;
        active_r  <= active_nxt;
        act_r     <= act_nxt;
      end
      if (cmd.finish) begin
        if (act_r != mnet_pkg::ACT_NONE) begin
          open_r <= (act_r == mnet_pkg::ACT_LEGATO) || (act_r == mnet_pkg::ACT_OPEN);
        end
        if (act_r == mnet_pkg::ACT_LEGATO || act_r == mnet_pkg::ACT_OPEN) begin
          open_pitch_r <= key_r;
          open_vel_r   <= vel_r;
          open_start_r <= quo_r;
          counter_r    <= counter_inc;
        end
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_key_number;
      vel_r <= in_key_velocity;
    end
    if (cmd.mul) begin
      prod_r <= elapsed_r * tempo_r;
      dvsr_r <= mnet_pkg::DVSR_W'(tpq_eff) * mnet_pkg::DVSR_W'(mnet_pkg::MS_PER_S);
    end
    if (cmd.check) begin
      rem_r <= {1'b0, prod_r[mnet_pkg::PROD_W-1:mnet_pkg::MS_W]};
      quo_r <= stat.sat ? '1 : prod_r[mnet_pkg::MS_W-1:0];
    end else if (cmd.step) begin
      rem_r <= rem_ge ? rem_diff[mnet_pkg::DVSR_W-1:0] : rem_sh[mnet_pkg::DVSR_W-1:0];
      quo_r <= {quo_r[mnet_pkg::MS_W-2:0], rem_ge};
    end
    if (load_out) begin
      out_index_r <= counter_r;
      out_start_r <= open_start_r;
      out_end_r   <= quo_r;
      out_pitch_r <= open_pitch_r;
      out_vel_r   <= open_vel_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_note_index = out_index_r;
  assign out_start_ms   = out_start_r;
  assign out_end_ms     = out_end_r;
  assign out_pitch      = out_pitch_r;
  assign out_velocity   = out_vel_r;

endmodule

// ===== rtl/core/mnet_ctrl.sv =====
// Controller of the MIDI note event tracker: sequences accept, multiply,
// range check, the bit-serial divide and the final state update.
// Depends on mnet_pkg.
module mnet_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mnet_pkg::ctrl_stat_t  stat,
  output mnet_pkg::ctrl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [mnet_pkg::STEP_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && stat.needs_time) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.sat ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == mnet_pkg::STEP_CNT_W'(mnet_pkg::DIV_STEPS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.can_finish) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/core/midi_note_event_tracker_unit.sv =====
// Top level of the MIDI note event tracker: joins the controller and the datapath.
// Depends on mnet_pkg, mnet_ctrl and mnet_datapath.
//
// Decoded MIDI file events enter on the in_ channel, one item per handshake;
// finished notes leave on the out_ channel with index, start and end times in
// milliseconds, pitch and velocity. Both channels use valid and stall.
// An item that only moves time, changes tempo or starts a track is taken
// without a stall. An item that opens or closes a note needs the current
// time in milliseconds: the 32x24 multiply, the range check and the
// shift-subtract divide run in turn while in_stall is held high, and its
// note, if any, appears on out_valid as in_stall falls. A result that
// saturates skips the divide. A finished note waits in the output register
// while new items are taken; the block only waits when a second note is
// ready before the first was taken. Configuration writes (cfg_we, cfg_index,
// cfg_wdata) should be made only while idle; the block itself does not
// enforce this. Synchronous reset clears all note and time state, sets
// ticks_per_quarter to 480 and track_select to 0, and leaves out_valid low.
module midi_note_event_tracker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mnet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mnet_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mnet_pkg::CMD_W-1:0]          in_cmd,
  input  logic [mnet_pkg::DELTA_W-1:0]        in_delta_ticks,
  input  logic [mnet_pkg::STATUS_W-1:0]       in_status_byte,
  input  logic [mnet_pkg::KEY_W-1:0]          in_key_number,
  input  logic [mnet_pkg::KEY_W-1:0]          in_key_velocity,
  input  logic [mnet_pkg::TRACK_W-1:0]        in_track_number,
  input  logic [mnet_pkg::KIND_W-1:0]         in_meta_kind,
  input  logic [mnet_pkg::LEN_W-1:0]          in_meta_length,
  input  logic [mnet_pkg::TEMPO_W-1:0]        in_tempo_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mnet_pkg::INDEX_W-1:0]        out_note_index,
  output logic [mnet_pkg::MS_W-1:0]           out_start_ms,
  output logic [mnet_pkg::MS_W-1:0]           out_end_ms,
  output logic [mnet_pkg::KEY_W-1:0]          out_pitch,
  output logic [mnet_pkg::KEY_W-1:0]          out_velocity
);

  mnet_pkg::ctrl_cmd_t  cmd;
  mnet_pkg::ctrl_stat_t stat;

  mnet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mnet_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_delta_ticks  (in_delta_ticks),
    .in_status_byte  (in_status_byte),
    .in_key_number   (in_key_number),
    .in_key_velocity (in_key_velocity),
    .in_track_number (in_track_number),
    .in_meta_kind    (in_meta_kind),
    .in_meta_length  (in_meta_length),
    .in_tempo_value  (in_tempo_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_note_index  (out_note_index),
    .out_start_ms    (out_start_ms),
    .out_end_ms      (out_end_ms),
    .out_pitch       (out_pitch),
    .out_velocity    (out_velocity),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// ===== rtl/core/mnet_checker.sv =====
// Port-level checks for the MIDI note event tracker, bound to the top level.
// Depends on mnet_pkg and midi_note_event_tracker_unit.
module mnet_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mnet_pkg::INDEX_W-1:0]  out_note_index,
  input logic [mnet_pkg::MS_W-1:0]     out_end_ms,
  input logic [mnet_pkg::KEY_W-1:0]    out_velocity
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_end_ms)))
    else $error("stalled result changed");

  a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_note_index != '0))
    else $error("note index zero");

  a_velocity_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_velocity != '0))
    else $error("note velocity zero");

endmodule

bind midi_note_event_tracker_unit mnet_checker u_mnet_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_note_index (out_note_index),
  .out_end_ms     (out_end_ms),
  .out_velocity   (out_velocity)
);

// ===== sim/tb.sv =====
// Testbench for midi_note_event_tracker_unit: directed and random MIDI events, an
// in-bench note predictor and a checker on the note output channel.
// Depends on mnet_pkg and the RTL top level.
module tb;
  import mnet_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [DELTA_W-1:0]  delta;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    vel;
    logic [TRACK_W-1:0]  track;
    logic [KIND_W-1:0]   kind;
    logic [LEN_W-1:0]    len;
    logic [TEMPO_W-1:0]  tempo;
  } midi_event_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [MS_W-1:0]    start_ms;
    logic [MS_W-1:0]    end_ms;
    logic [KEY_W-1:0]   pitch;
    logic [KEY_W-1:0]   velocity;
  } note_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [DELTA_W-1:0] in_delta_ticks = '0;
  logic [STATUS_W-1:0] in_status_byte = '0;
  logic [KEY_W-1:0] in_key_number = '0;
  logic [KEY_W-1:0] in_key_velocity = '0;
  logic [TRACK_W-1:0] in_track_number = '0;
  logic [KIND_W-1:0] in_meta_kind = '0;
  logic [LEN_W-1:0] in_meta_length = '0;
  logic [TEMPO_W-1:0] in_tempo_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [INDEX_W-1:0] out_note_index;
  logic [MS_W-1:0] out_start_ms;
  logic [MS_W-1:0] out_end_ms;
  logic [KEY_W-1:0] out_pitch;
  logic [KEY_W-1:0] out_velocity;

  midi_note_event_tracker_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_delta_ticks(in_delta_ticks), .in_status_byte(in_status_byte),
    .in_key_number(in_key_number), .in_key_velocity(in_key_velocity),
    .in_track_number(in_track_number), .in_meta_kind(in_meta_kind),
    .in_meta_length(in_meta_length), .in_tempo_value(in_tempo_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_note_index(out_note_index),
    .out_start_ms(out_start_ms), .out_end_ms(out_end_ms),
    .out_pitch(out_pitch), .out_velocity(out_velocity)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  midi_event_t pending[$];
  note_t notes_due[$];
  int queued_total = 0;
  int taken_total = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_gap_max = 8;
  int stall_max = 8;
  int hold_req = 0;

  logic [TRACK_W-1:0] sel_track = '0;
  logic [TPQ_W-1:0] tpq_reg = TPQ_W'(TPQ_RESET);
  logic [TICKS_W-1:0] cur_ticks = '0;
  logic [TEMPO_W-1:0] cur_tempo = '0;
  logic on_track = 1'b0;
  logic holding = 1'b0;
  logic [KEY_W-1:0] held_pitch = '0;
  logic [KEY_W-1:0] held_vel = '0;
  logic [MS_W-1:0] held_start = '0;
  logic [INDEX_W-1:0] notes_made = '0;

  function automatic logic [MS_W-1:0] current_ms();
    logic [63:0] prod;
    logic [63:0] divisor;
    logic [63:0] q;
    prod = {32'd0, cur_ticks} * {40'd0, cur_tempo};
    divisor = 64'd1000 * ((tpq_reg == '0) ? 64'd1 : {49'd0, tpq_reg});
    q = prod / divisor;
    return (q > 64'hFFFF_FFFF) ? '1 : q[MS_W-1:0];
  endfunction

  function automatic void add_ticks(input logic [DELTA_W-1:0] d);
    logic [TICKS_W:0] sum;
    sum = {1'b0, cur_ticks} + {5'd0, d};
    cur_ticks = sum[TICKS_W] ? '1 : sum[TICKS_W-1:0];
  endfunction

  function automatic void finish_note(input logic [MS_W-1:0] t);
    notes_due.push_back(note_t'{notes_made, held_start, t, held_pitch, held_vel});
    holding = 1'b0;
  endfunction

  function automatic void start_note(input logic [KEY_W-1:0] k, input logic [KEY_W-1:0] v,
                                     input logic [MS_W-1:0] t);
    notes_made = notes_made + 1'b1;
    if (notes_made == '0) notes_made = INDEX_W'(1);
    holding = 1'b1;
    held_pitch = k;
    held_vel = v;
    held_start = t;
  endfunction

  function automatic void apply_event(input midi_event_t ev);
    logic [MS_W-1:0] t;
    case (ev.cmd)
      CMD_START: begin
        cur_ticks = '0;
        on_track = (ev.track == sel_track);
      end
      CMD_SYSEX: begin
        if (on_track) add_ticks(ev.delta);
      end
      CMD_META: begin
        if (on_track) add_ticks(ev.delta);
        if (ev.kind == META_TEMPO && ev.len == META_TEMPO_LEN) cur_tempo = ev.tempo;
      end
      CMD_CHAN: begin
        if (on_track) begin
          add_ticks(ev.delta);
          if (ev.status[7:4] == NIB_NOTE_ON) begin
            if (holding) begin
              if (held_pitch == ev.key) begin
                if (ev.vel == '0) finish_note(current_ms());
              end else if (ev.vel != '0) begin
                t = current_ms();
                finish_note(t);
                start_note(ev.key, ev.vel, t);
              end
            end else if (ev.vel != '0) begin
              start_note(ev.key, ev.vel, current_ms());
            end
          end else if (ev.status[7:4] == NIB_NOTE_OFF && holding) begin
            finish_note(current_ms());
          end
        end
      end
    endcase
  endfunction

  function automatic midi_event_t rand_event();
    midi_event_t ev;
    ev.cmd = CMD_W'($urandom);
    ev.delta = DELTA_W'($urandom);
    ev.status = STATUS_W'($urandom);
    ev.key = KEY_W'($urandom);
    ev.vel = KEY_W'($urandom);
    ev.track = TRACK_W'($urandom);
    ev.kind = KIND_W'($urandom);
    ev.len = LEN_W'($urandom);
    ev.tempo = TEMPO_W'($urandom);
    return ev;
  endfunction

  function automatic midi_event_t ev_chan(input logic [DELTA_W-1:0] d,
                                         input logic [STATUS_W-1:0] s,
                                         input logic [KEY_W-1:0] k, input logic [KEY_W-1:0] v);
    midi_event_t ev;
    ev = rand_event();
    ev.cmd = CMD_CHAN;
    ev.delta = d;
    ev.status = s;
    ev.key = k;
    ev.vel = v;
    return ev;
  endfunction

  function automatic midi_event_t ev_meta(input logic [DELTA_W-1:0] d,
                                         input logic [KIND_W-1:0] kd,
                                         input logic [LEN_W-1:0] ln,
                                         input logic [TEMPO_W-1:0] tp);
    midi_event_t ev;
    ev = rand_event();
    ev.cmd = CMD_META;
    ev.delta = d;
    ev.kind = kd;
    ev.len = ln;
    ev.tempo = tp;
    return ev;
  endfunction

  function automatic midi_event_t ev_start(input logic [TRACK_W-1:0] tr);
    midi_event_t ev;
    ev = rand_event();
    ev.cmd = CMD_START;
    ev.track = tr;
    return ev;
  endfunction

  function automatic midi_event_t ev_sysex(input logic [DELTA_W-1:0] d);
    midi_event_t ev;
    ev = rand_event();
    ev.cmd = CMD_SYSEX;
    ev.delta = d;
    return ev;
  endfunction

  function automatic logic [DELTA_W-1:0] pick_delta();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '1;
    if (r < 4) return DELTA_W'($urandom);
    if (r < 10) return DELTA_W'($urandom_range(0, 20000));
    return DELTA_W'($urandom_range(0, 500));
  endfunction

  task automatic queue_event(input midi_event_t ev);
    pending.push_back(ev);
    queued_total++;
  endtask

  // Most random items form a track: a start event followed by note traffic on a
  // small set of keys, so that legato, release and retrigger cases come up often.
  task automatic fill_random(input int n);
    int count;
    int r;
    int p;
    int span;
    logic [KEY_W-1:0] pool [3];
    logic [KEY_W-1:0] k;
    logic [3:0] chan;
    logic [TEMPO_W-1:0] tp;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_event(rand_event());
        count++;
      end else if (r < 11) begin
        for (int i = 0; i < 17; i++)
          queue_event(ev_meta('1, KIND_W'($urandom), LEN_W'($urandom), TEMPO_W'($urandom)));
        count += 17;
      end else begin
        queue_event(ev_start(($urandom_range(0, 4) != 0) ? sel_track : TRACK_W'($urandom)));
        pool = '{KEY_W'($urandom), KEY_W'($urandom), KEY_W'($urandom)};
        span = $urandom_range(5, 30);
        for (int i = 0; i < span; i++) begin
          p = $urandom_range(0, 99);
          k = pool[2'($urandom_range(0, 2))];
          chan = 4'($urandom);
          if (p < 40) begin
            queue_event(ev_chan(pick_delta(), {NIB_NOTE_ON, chan}, k,
                                KEY_W'(($urandom_range(0, 6) == 0) ? 0 :
                                       $urandom_range(1, 127))));
          end else if (p < 60) begin
            queue_event(ev_chan(pick_delta(), {NIB_NOTE_OFF, chan},
                                $urandom_range(0, 1) ? k : KEY_W'($urandom),
                                KEY_W'($urandom)));
          end else if (p < 70) begin
            queue_event(ev_chan(pick_delta(), {NIB_NOTE_ON, chan}, k, '0));
          end else if (p < 76) begin
            queue_event(ev_chan(pick_delta(), STATUS_W'($urandom), KEY_W'($urandom),
                                KEY_W'($urandom)));
          end else if (p < 82) begin
            queue_event(ev_sysex(pick_delta()));
          end else if (p < 90) begin
            r = $urandom_range(0, 19);
            if (r == 0) tp = '0;
            else if (r == 1) tp = '1;
            else if (r < 10) tp = TEMPO_W'($urandom_range(250000, 1000000));
            else tp = TEMPO_W'($urandom);
            queue_event(ev_meta(pick_delta(), META_TEMPO, META_TEMPO_LEN, tp));
          end else if (p < 96) begin
            queue_event(ev_meta(pick_delta(), KIND_W'($urandom),
                                $urandom_range(0, 1) ? META_TEMPO_LEN : LEN_W'($urandom),
                                TEMPO_W'($urandom)));
          end else begin
            queue_event(rand_event());
          end
        end
        count += span + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TRACK_SELECT) sel_track = data;
    else tpq_reg = data[TPQ_W-1:0];
  endtask

  task automatic drain();
    while (taken_total != queued_total || notes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [TRACK_W-1:0] sel, input logic [CFG_DATA_W-1:0] tpq,
                           input int gap, input int stall, input int n, input bit hold);
    write_reg(REG_TRACK_SELECT, sel);
    write_reg(REG_TPQ, tpq);
    send_gap_max = gap;
    stall_max = stall;
    @(negedge clk);
    fill_random(n);
    if (hold) hold_req++;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_event(ev_meta(7, META_TEMPO, META_TEMPO_LEN, 500000));
    queue_event(ev_chan(10, {NIB_NOTE_ON, 4'h0}, 60, 100));
    queue_event(ev_start(0));
    queue_event(ev_chan(3, {NIB_NOTE_OFF, 4'h0}, 60, 0));
    queue_event(ev_chan(4, {NIB_NOTE_ON, 4'h0}, 60, 0));
    queue_event(ev_chan(480, {NIB_NOTE_ON, 4'h0}, 60, 100));
    queue_event(ev_chan(20, {NIB_NOTE_ON, 4'h1}, 60, 50));
    queue_event(ev_chan(20, {NIB_NOTE_ON, 4'h2}, 61, 0));
    queue_event(ev_chan(960, {NIB_NOTE_ON, 4'hF}, 64, 127));
    queue_event(ev_start(1));
    queue_event(ev_sysex(5000));
    queue_event(ev_start(0));
    queue_event(ev_chan(100, {NIB_NOTE_ON, 4'h0}, 64, 0));
    queue_event(ev_chan(0, {NIB_NOTE_ON, 4'h0}, 0, 1));
    queue_event(ev_chan(240, 8'hA0, 0, 127));
    queue_event(ev_sysex(1000));
    queue_event(ev_meta(30, META_TEMPO, 4, 123456));
    queue_event(ev_meta(30, 7'h2F, META_TEMPO_LEN, 654321));
    queue_event(ev_chan(50, {NIB_NOTE_OFF, 4'hF}, 5, 127));
    queue_event(ev_meta(0, META_TEMPO, META_TEMPO_LEN, 0));
    queue_event(ev_chan(99, {NIB_NOTE_ON, 4'h0}, 127, 127));
    queue_event(ev_chan(7, {NIB_NOTE_OFF, 4'h0}, 127, 0));
    queue_event(ev_meta(0, META_TEMPO, META_TEMPO_LEN, '1));
    queue_event(ev_chan('1, {NIB_NOTE_ON, 4'h0}, 1, 127));
    queue_event(ev_chan('1, {NIB_NOTE_OFF, 4'h0}, 1, 0));
    drain();
    run_phase(16'h0000, 16'd480, 8, 8, 260, 1'b1);
    run_phase(16'hFFFF, 16'd1, 0, 0, 260, 1'b0);
    run_phase(TRACK_W'($urandom), 16'hFFFF, 8, 0, 260, 1'b0);
    run_phase(16'd3, 16'd0, 0, 8, 260, 1'b0);
    run_phase(TRACK_W'($urandom), 16'd96, 8, 8, 260, 1'b1);
    run_phase(TRACK_W'($urandom), CFG_DATA_W'($urandom_range(1, 32767)), 4, 4, 260, 1'b0);
    run_phase(16'h0000, 16'd480, 0, 0, 260, 1'b0);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  midi_event_t cur_ev;
  int send_wait = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_event(cur_ev);
        taken_total++;
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (pending.size() > 0) begin
          cur_ev = pending.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_ev.cmd;
          in_delta_ticks <= cur_ev.delta;
          in_status_byte <= cur_ev.status;
          in_key_number <= cur_ev.key;
          in_key_velocity <= cur_ev.vel;
          in_track_number <= cur_ev.track;
          in_meta_kind <= cur_ev.kind;
          in_meta_length <= cur_ev.len;
          in_tempo_value <= cur_ev.tempo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int recv_wait = 0;
  int hold_left = 0;
  int hold_seen = 0;
  note_t got;
  note_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_note_index, out_start_ms, out_end_ms, out_pitch, out_velocity};
        if (notes_due.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("unexpected note: idx %0d start %0d end %0d pitch %0d vel %0d",
                     got.index, got.start_ms, got.end_ms, got.pitch, got.velocity);
          fail_count++;
        end else begin
          want = notes_due.pop_front();
          if (got.index !== want.index || got.start_ms !== want.start_ms ||
              got.end_ms !== want.end_ms || got.pitch !== want.pitch ||
              got.velocity !== want.velocity) begin
            if (fail_count < REPORT_MAX) begin
              $display("note mismatch: expected idx %0d start %0d end %0d pitch %0d vel %0d",
                       want.index, want.start_ms, want.end_ms, want.pitch, want.velocity);
              $display("                    got idx %0d start %0d end %0d pitch %0d vel %0d",
                       got.index, got.start_ms, got.end_ms, got.pitch, got.velocity);
            end
            fail_count++;
          end
        end
        recv_wait = $urandom_range(0, stall_max);
      end
      if (hold_seen != hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_req;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (recv_wait > 0) begin
        out_stall <= 1'b1;
        if (out_valid) recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/mnet_pkg.sv
rtl/core/mnet_datapath.sv
rtl/core/mnet_ctrl.sv
rtl/core/midi_note_event_tracker_unit.sv
rtl/core/mnet_checker.sv
sim/tb.sv
